// File: rtl/core/nms_pkg.sv
// Shared types and constants for the IoU non-maximum suppression unit.
// Used by the top level, the IoU compare pipeline and the port checker.
`default_nettype none

package nms_pkg;

  localparam int MAX_KEPT   = 256;
  localparam int KIDX_W     = $clog2(MAX_KEPT);
  localparam int CNT_W      = $clog2(MAX_KEPT + 1);
  localparam int THR_W      = 17;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int POS_W      = 16;
  localparam int AREA_W     = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

  typedef struct packed {
    logic [15:0]        height;
    logic [15:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } nms_box_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    nms_box_t          box;
  } nms_entry_t;

  typedef struct packed {
    logic busy;
    logic vld;
    logic hit;
  } nms_cmp_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } nms_state_t;

endpackage

`default_nettype wire

// File: rtl/core/nms_iou_cmp.sv
// Six-stage IoU compare pipeline: one stored box against the current box per beat.
// Depends on nms_pkg for the box and status types.
`default_nettype none

module nms_iou_cmp (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        vld_i,
  input  nms_pkg::nms_box_t          cur_i,
  input  wire [nms_pkg::AREA_W-1:0]  cur_area_i,
  input  nms_pkg::nms_entry_t        kept_i,
  input  wire [nms_pkg::THR_W-1:0]   thr_i,
  output nms_pkg::nms_cmp_st_t       st_o
);
  import nms_pkg::*;

  logic [5:0] vld_r;

  // Stage 1: far edges and near overlap bounds.
  logic signed [17:0] ax1_r, bx1_r, xlo_r, ay1_r, by1_r, ylo_r;
  logic [AREA_W-1:0]  karea1_r;
  logic signed [17:0] ax0, bx0, ay0, by0;

  // Stage 2: overlap lengths.
  logic [15:0]        ix_r, iy_r;
  logic [AREA_W-1:0]  karea2_r;
  logic signed [17:0] xhi, yhi, xdiff, ydiff;

  // Stages 3 to 6.
  logic [AREA_W-1:0]  inter3_r, inter4_r, inter5_r;
  logic [AREA_W:0]    sum3_r, uni4_r;
  logic [THR_W+AREA_W:0] prod5_r;
  logic [THR_W+AREA_W:0] lhs5;
  logic               hit_r;

  assign ax0 = {{2{cur_i.left[15]}}, cur_i.left};
  assign bx0 = {{2{kept_i.box.left[15]}}, kept_i.box.left};
  assign ay0 = {{2{cur_i.top[15]}}, cur_i.top};
  assign by0 = {{2{kept_i.box.top[15]}}, kept_i.box.top};

  assign xhi   = (ax1_r < bx1_r) ? ax1_r : bx1_r;
  assign yhi   = (ay1_r < by1_r) ? ay1_r : by1_r;
  assign xdiff = xhi - xlo_r;
  assign ydiff = yhi - ylo_r;

  assign lhs5 = {2'b00, inter5_r, 16'h0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    ax1_r    <= ax0 + $signed({2'b00, cur_i.width});
    bx1_r    <= bx0 + $signed({2'b00, kept_i.box.width});
    xlo_r    <= (ax0 > bx0) ? ax0 : bx0;
    ay1_r    <= ay0 + $signed({2'b00, cur_i.height});
    by1_r    <= by0 + $signed({2'b00, kept_i.box.height});
    ylo_r    <= (ay0 > by0) ? ay0 : by0;
    karea1_r <= kept_i.area;

    ix_r     <= (xhi > xlo_r) ? xdiff[15:0] : 16'h0000;
    iy_r     <= (yhi > ylo_r) ? ydiff[15:0] : 16'h0000;
    karea2_r <= karea1_r;

    inter3_r <= {16'h0000, ix_r} * {16'h0000, iy_r};
    sum3_r   <= {1'b0, cur_area_i} + {1'b0, karea2_r};

    inter4_r <= inter3_r;
    uni4_r   <= sum3_r - {1'b0, inter3_r};

    inter5_r <= inter4_r;
    prod5_r  <= {{(AREA_W+1){1'b0}}, thr_i} * {{THR_W{1'b0}}, uni4_r};

    hit_r    <= lhs5 > prod5_r;
  end

  assign st_o.busy = |vld_r;
  assign st_o.vld  = vld_r[5];
  assign st_o.hit  = hit_r;

endmodule

`default_nettype wire

// File: rtl/core/iou_non_maximum_suppression_unit.sv
// Greedy IoU non-maximum suppression: top level with the kept-box store and control.
// Depends on nms_pkg and nms_iou_cmp.
// A result is registered once its beat has been checked against every stored box, and the
// next beat can be taken in the cycle after. The scan is paced by the single read port of
// the kept store, visited once per stored box. One item is in work at a time; the result
// register lets the next beat in while it waits. Reset clears the state machine, kept
// count and set position and sets the threshold to THR_RESET; no store sweep.
`default_nettype none

module iou_non_maximum_suppression_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48]
  input  wire [nms_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                              in_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // keep[0], box_index[16:1], store_full[17], zero fill [23:18]
  output logic [nms_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_wr_en,
  input  wire [nms_pkg::THR_W-1:0]         cfg_wr_data
);
  import nms_pkg::*;

  nms_entry_t mem [MAX_KEPT];

  nms_state_t        state_r, state_nxt;
  nms_box_t          box_r, box_nxt;
  logic              last_r, last_nxt;
  logic [AREA_W-1:0] area_r;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_en, rd_vld_r;
  nms_entry_t        rd_data_r;
  logic              supp_r, supp_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              mem_we;
  nms_entry_t        wr_data;
  logic              out_vld_r, out_vld_nxt;
  logic              out_keep_r, out_keep_nxt;
  logic [POS_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_full_r, out_full_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;
  logic              room;
  nms_cmp_st_t       cmp_st;

  nms_iou_cmp u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (rd_vld_r),
    .cur_i      (box_r),
    .cur_area_i (area_r),
    .kept_i     (rd_data_r),
    .thr_i      (thr_r),
    .st_o       (cmp_st)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_vld_r || out_tready;
  assign room      = count_r < CNT_W'(MAX_KEPT);
  assign wr_data   = '{area: area_r, box: box_r};

  always_comb begin
    state_nxt    = state_r;
    box_nxt      = box_r;
    last_nxt     = last_r;
    rd_idx_nxt   = rd_idx_r;
    rd_en        = 1'b0;
    supp_nxt     = supp_r | (cmp_st.vld & cmp_st.hit);
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    mem_we       = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_keep_nxt = out_keep_r;
    out_idx_nxt  = out_idx_r;
    out_full_nxt = out_full_r;
    out_last_nxt = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          box_nxt.left   = in_tdata[15:0];
          box_nxt.top    = in_tdata[31:16];
          box_nxt.width  = in_tdata[47:32];
          box_nxt.height = in_tdata[63:48];
          last_nxt       = in_tlast;
          supp_nxt       = 1'b0;
          rd_idx_nxt     = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_r < count_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !cmp_st.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_keep_nxt = !supp_r;
          out_idx_nxt  = pos_r;
          out_full_nxt = !supp_r && !room;
          out_last_nxt = last_r;
          if (!supp_r && room) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (last_r) begin
            count_nxt = '0;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_vld_r  <= 1'b0;
      count_r   <= '0;
      pos_r     <= '0;
      thr_r     <= THR_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_en;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    box_r      <= box_nxt;
    last_r     <= last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    supp_r     <= supp_nxt;
    area_r     <= {16'h0000, box_r.width} * {16'h0000, box_r.height};
    out_keep_r <= out_keep_nxt;
    out_idx_r  <= out_idx_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[KIDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[KIDX_W-1:0]];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b000000, out_full_r, out_idx_r, out_keep_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/nms_checker.sv
// Port-level checker for the IoU non-maximum suppression unit, with its bind.
// Sees only the top-level ports; depends on nms_pkg for widths.
`default_nettype none

module nms_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [nms_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tlast
);
  import nms_pkg::*;

  logic in_beat;

  assign in_beat = in_tvalid && in_tready;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input accepted while a box is still in work");

  a_full_implies_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[17] && !out_tdata[0]))
    else $error("store_full raised on a suppressed box");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("unit not idle after reset");

endmodule

bind iou_non_maximum_suppression_unit nms_checker u_nms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
